// File: design/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  // Default operand width (numerator bits; denominators are one bit less)
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Operation codes
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CMP   = 3'd4,
    OP_SIMP  = 3'd5,
    OP_RECIP = 3'd6,
    OP_BAD   = 3'd7
  } op_e;

  // Compare result codes
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD,
    ST_FIN
  } state_e;

  // Gcd / divide unit phases
  typedef enum logic [1:0] {
    GPH_IDLE,
    GPH_RED,
    GPH_DIVX,
    GPH_DIVY
  } gph_e;

endpackage

`default_nettype wire

// File: design/rau_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier with registered product
module rau_mul #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic signed [VALUE_WIDTH:0] a_i,
  input  wire logic signed [VALUE_WIDTH:0] b_i,
  output logic signed [63:0]              p_o
);
  localparam int unsigned PW = 2 * VALUE_WIDTH + 2;

  logic signed [PW-1:0] prod;
  logic signed [63:0]   p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(prod);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: design/rau_gcd.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary gcd of x and y, then exact restoring division of both by the gcd.
// One subtractor serves the reduction and both divisions.
module rau_gcd #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] x_i,
  input  wire logic [VALUE_WIDTH-1:0] y_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      qx_o,
  output logic [VALUE_WIDTH-1:0]      qy_o
);
  import rau_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned KW = $clog2(W);

  gph_e          ph_q, ph_d;
  logic [W-1:0]  x_q, x_d, y_q, y_d;
  logic [W-1:0]  a0_q, a0_d, a1_q, a1_d;
  logic [W-1:0]  g_q, g_d, rem_q, rem_d, quo_q, quo_d, qx_q, qx_d;
  logic [KW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic          done_q, done_d;

  logic [W:0]    sub_a, sub_b, diff, trial;
  logic          fits;
  logic [W-1:0]  quo_nxt;

  // Shared subtractor
  assign trial   = {rem_q, quo_q[W-1]};
  assign sub_a   = (ph_q == GPH_RED) ? {1'b0, x_q} : trial;
  assign sub_b   = (ph_q == GPH_RED) ? {1'b0, y_q} : {1'b0, g_q};
  assign diff    = sub_a - sub_b;
  assign fits    = ~diff[W];
  assign quo_nxt = {quo_q[W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= GPH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    a0_q  <= a0_d;
    a1_q  <= a1_d;
    g_q   <= g_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    qx_q  <= qx_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
  end

  // Step sequencer
  always_comb begin
    ph_d   = ph_q;
    x_d    = x_q;
    y_d    = y_q;
    a0_d   = a0_q;
    a1_d   = a1_q;
    g_d    = g_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    qx_d   = qx_q;
    k_d    = k_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (ph_q)
      GPH_IDLE: begin
        if (start_i) begin
          x_d  = x_i;
          y_d  = y_i;
          a0_d = x_i;
          a1_d = y_i;
          k_d  = '0;
          ph_d = GPH_RED;
        end
      end
      GPH_RED: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (diff == '0) begin
          g_d   = x_q << k_q;
          rem_d = '0;
          quo_d = a0_q;
          cnt_d = '0;
          ph_d  = GPH_DIVX;
        end else if (diff[W]) begin
          // x below y: swap, subtract next step
          x_d = y_q;
          y_d = x_q;
        end else begin
          x_d = {1'b0, diff[W-1:1]};
        end
      end
      GPH_DIVX, GPH_DIVY: begin
        rem_d = fits ? diff[W-1:0] : trial[W-1:0];
        quo_d = quo_nxt;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == KW'(W - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          if (ph_q == GPH_DIVX) begin
            qx_d  = quo_nxt;
            quo_d = a1_q;
            ph_d  = GPH_DIVY;
          end else begin
            done_d = 1'b1;
            ph_d   = GPH_IDLE;
          end
        end
      end
      default: ph_d = GPH_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign qx_o   = qx_q;
  assign qy_o   = quo_q;

  // Operands never reach zero during reduction
  a_red_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == GPH_RED) |-> (x_q != '0 && y_q != '0))
    else $error("gcd operand reached zero");

  // Done only after the second division
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(ph_q == GPH_DIVY))
    else $error("gcd done outside second division");

  // Remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == GPH_DIVX || ph_q == GPH_DIVY) |-> (rem_q < g_q))
    else $error("division remainder out of range");

endmodule

`default_nettype wire

// File: design/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Exact arithmetic on two fractions a and b: add, subtract, multiply, divide,
// compare, simplify a, reciprocal a. One word is taken at a time; in_stall_o
// stays high until its result has been placed in the output register, and the
// next word may be taken while that result still waits. Equal-denominator
// add/subtract, reciprocal and error cases go straight to the output stage;
// multiply, divide, compare and cross-multiplied add/subtract use the single
// shared multiplier once per product. Simplify runs binary gcd reduction and
// then restoring division of numerator and denominator, all on one shared
// subtractor. Results carry their sign in res_num_o, a zero numerator comes
// with denominator 1, and error_o marks a zero denominator, an invalid op, a
// division by zero or the reciprocal of zero, with result 0/1.
module rational_arithmetic_unit #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [30:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [30:0] b_den_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      res_num_o,
  output logic [62:0]      res_den_o,
  output logic [1:0]       order_o,
  output logic             error_o
);
  import rau_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  state_e state_q, state_d;

  logic [2:0]          op_q;
  logic signed [W-1:0] an_q, bn_q;
  logic [W-2:0]        ad_q, bd_q;
  logic signed [63:0]  p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic signed [63:0]  r_num_q, r_num_d, r_den_q, r_den_d;
  logic [1:0]          r_ord_q, r_ord_d;
  logic                r_err_q, r_err_d;
  logic [1:0]          mcnt_q, mcnt_d;

  logic                out_valid_q;
  logic [63:0]         res_num_q;
  logic [62:0]         res_den_q;
  logic [1:0]          order_q;
  logic                error_q;

  logic                accept, load_out, gcd_start, gcd_done;
  logic signed [W-1:0] an_w, bn_w;
  logic [W-2:0]        ad_w, bd_w;
  logic [W-1:0]        an_mag, qx, qy;
  logic signed [W:0]   ma, mb;
  logic signed [63:0]  mp;
  logic [1:0]          mlast;
  logic signed [63:0]  n_num, n_den, fin_den;

  assign accept   = in_valid_i && !in_stall_o;
  assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != ST_IDLE);

  // Operands cut to the configured width
  assign an_w   = a_num_i[W-1:0];
  assign bn_w   = b_num_i[W-1:0];
  assign ad_w   = a_den_i[W-2:0];
  assign bd_w   = b_den_i[W-2:0];
  assign an_mag = an_w[W-1] ? (~an_w + 1'b1) : an_w;
  assign gcd_start = accept && (op_i == OP_SIMP) && (ad_w != '0) && (an_w != '0);

  // Multiplier operand select
  always_comb begin
    ma = {an_q[W-1], an_q};
    mb = {2'b00, bd_q};
    case (mcnt_q)
      2'd0: begin
        ma = {an_q[W-1], an_q};
        mb = (op_q == OP_MUL) ? {bn_q[W-1], bn_q} : {2'b00, bd_q};
      end
      2'd1: begin
        ma = {2'b00, ad_q};
        mb = (op_q == OP_MUL) ? {2'b00, bd_q} : {bn_q[W-1], bn_q};
      end
      default: begin
        ma = {2'b00, ad_q};
        mb = {2'b00, bd_q};
      end
    endcase
  end

  assign mlast = (op_q == OP_ADD || op_q == OP_SUB) ? 2'd3 : 2'd2;

  rau_mul #(.VALUE_WIDTH(W)) u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (mp)
  );

  rau_gcd #(.VALUE_WIDTH(W)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (an_mag),
    .y_i     ({1'b0, ad_w}),
    .done_o  (gcd_done),
    .qx_o    (qx),
    .qy_o    (qy)
  );

  // Sign moves to the numerator, zero gets denominator 1
  assign n_num   = r_den_q[63] ? -r_num_q : r_num_q;
  assign n_den   = r_den_q[63] ? -r_den_q : r_den_q;
  assign fin_den = (n_num == '0) ? 64'sd1 : n_den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      mcnt_q  <= mcnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_i;
      an_q <= an_w;
      bn_q <= bn_w;
      ad_q <= ad_w;
      bd_q <= bd_w;
    end
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    r_num_q <= r_num_d;
    r_den_q <= r_den_d;
    r_ord_q <= r_ord_d;
    r_err_q <= r_err_d;
    if (load_out) begin
      res_num_q <= n_num;
      res_den_q <= fin_den[62:0];
      order_q   <= r_ord_q;
      error_q   <= r_err_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    mcnt_d  = mcnt_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    r_num_d = r_num_q;
    r_den_d = r_den_q;
    r_ord_d = r_ord_q;
    r_err_d = r_err_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          r_num_d = '0;
          r_den_d = 64'sd1;
          r_ord_d = ORD_EQ;
          r_err_d = 1'b1;
          mcnt_d  = '0;
          state_d = ST_FIN;
          if (!(op_i == OP_BAD || ad_w == '0 || (op_i <= OP_CMP && bd_w == '0))) begin
            case (op_i)
              OP_ADD, OP_SUB: begin
                r_err_d = 1'b0;
                if (ad_w == bd_w) begin
                  r_num_d = (op_i == OP_ADD) ? 64'(an_w) + 64'(bn_w)
                                             : 64'(an_w) - 64'(bn_w);
                  r_den_d = 64'(ad_w);
                end else begin
                  state_d = ST_MUL;
                end
              end
              OP_MUL, OP_CMP: begin
                r_err_d = 1'b0;
                state_d = ST_MUL;
              end
              OP_DIV: begin
                if (bn_w != '0) begin
                  r_err_d = 1'b0;
                  state_d = ST_MUL;
                end
              end
              OP_SIMP: begin
                r_err_d = 1'b0;
                if (an_w != '0) begin
                  state_d = ST_GCD;
                end
              end
              OP_RECIP: begin
                if (an_w != '0) begin
                  r_err_d = 1'b0;
                  r_num_d = an_w[W-1] ? -64'(ad_w) : 64'(ad_w);
                  r_den_d = 64'(an_mag);
                end
              end
              default: state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_MUL: begin
        // product of the previous slot arrives now
        case (mcnt_q)
          2'd1:    p0_d = mp;
          2'd2:    p1_d = mp;
          2'd3:    p2_d = mp;
          default: p0_d = p0_q;
        endcase
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == mlast) begin
          mcnt_d  = '0;
          state_d = ST_COMB;
        end
      end
      ST_COMB: begin
        state_d = ST_FIN;
        case (op_q)
          OP_ADD: begin
            r_num_d = p0_q + p1_q;
            r_den_d = p2_q;
          end
          OP_SUB: begin
            r_num_d = p0_q - p1_q;
            r_den_d = p2_q;
          end
          OP_CMP: begin
            r_num_d = '0;
            r_den_d = 64'sd1;
            r_ord_d = (p0_q < p1_q) ? ORD_LT : ((p0_q == p1_q) ? ORD_EQ : ORD_GT);
          end
          default: begin
            r_num_d = p0_q;
            r_den_d = p1_q;
          end
        endcase
      end
      ST_GCD: begin
        if (gcd_done) begin
          r_num_d = an_q[W-1] ? -64'(qx) : 64'(qx);
          r_den_d = 64'(qy);
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign order_o     = order_q;
  assign error_o     = error_q;

  // An error result is always 0/1
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (res_num_o == '0 && res_den_o == 63'd1))
    else $error("error result is not 0/1");

  // Delivered denominator is never zero
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_den_o != '0))
    else $error("zero denominator delivered");

  // A stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_num_o)
                                      && $stable(res_den_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
